@@ rtl/frnt_pkg.sv @@
// Shared types, codes and constants for the fragment reassembly tracker.
package frnt_pkg;

  localparam int MAX_FRAGMENTS = 64;
  localparam int IDX_W = $clog2(MAX_FRAGMENTS);
  localparam int CNT_W = $clog2(MAX_FRAGMENTS + 1);
  localparam int BASE_W = 16;
  localparam int MAYDAY_W = 16;
  localparam int WORD_W = 32;

  localparam logic [BASE_W-1:0] WAIT_BASE_RESET = 16'd1000;
  localparam logic [MAYDAY_W-1:0] MAYDAY_MAX = '1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_FRAG  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_LIST  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_OUT_OF_RANGE = 4'd0,
    ST_DUPLICATE    = 4'd1,
    ST_ACCEPTED     = 4'd2,
    ST_COMPLETE     = 4'd3,
    ST_MAYDAY       = 4'd4,
    ST_NO_MAYDAY    = 4'd5,
    ST_MISSING      = 4'd6,
    ST_STARTED      = 4'd7,
    ST_NONE_MISSING = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_FRAG,
    S_TICK_INC,
    S_TICK_CMP,
    S_TICK_MUL,
    S_TICK_ADD,
    S_LIST
  } state_t;

  // Operands for the shared adder / comparator.
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] sum_sat;
    logic              ge;
  } alu_rsp_t;

  // One result item.
  typedef struct packed {
    status_t              status;
    logic [IDX_W-1:0]     missing_index;
    logic                 last;
    logic [CNT_W-1:0]     received_count;
    logic [MAYDAY_W-1:0]  mayday_count;
  } out_item_t;

endpackage

@@ rtl/frnt_alu.sv @@
// Shared 32-bit saturating adder and unsigned comparator.
module frnt_alu
  import frnt_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [WORD_W:0] sum;

  assign sum         = {1'b0, req.a} + {1'b0, req.b};
  assign rsp.sum_sat = sum[WORD_W] ? {WORD_W{1'b1}} : sum[WORD_W-1:0];
  assign rsp.ge      = (req.a >= req.b);

endmodule

@@ rtl/frnt_obuf.sv @@
// Output register stage holding one result item until it is taken.
module frnt_obuf
  import frnt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_item,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t item
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      item <= push_item;
    end
  end

endmodule

@@ rtl/fragment_reassembly_nack_tracker_core.sv @@
// Top level: sequencer, tracker state and received map around the shared adder.
//
//  channel | signals                                             | handshake
//  --------+-----------------------------------------------------+-----------------
//  in      | command, frag_index, last_fragment_index            | in_valid/in_ready
//  out     | status, missing_index, last, received_count,        | out_valid/out_ready
//          | mayday_count                                        |
//  cfg     | cfg_data (wait_base)                                | cfg_we
//
// Start and fragment items pass S_START or S_FRAG; a tick passes S_TICK_INC and
// S_TICK_CMP, then S_TICK_MUL (multiply) and S_TICK_ADD (wait update through the
// shared adder) when a mayday is due. A list item scans the map one index per
// cycle unless a full output register stalls it, then emits the final result.
// A result leaves through an output register; the sequencer waits only when
// that register is still full. Reset is synchronous and needs no clearing pass.
module fragment_reassembly_nack_tracker_core
  import frnt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          command,
  input  logic [IDX_W-1:0]    frag_index,
  input  logic [IDX_W-1:0]    last_fragment_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          status,
  output logic [IDX_W-1:0]    missing_index,
  output logic                last,
  output logic [CNT_W-1:0]    received_count,
  output logic [MAYDAY_W-1:0] mayday_count,
  input  logic                cfg_we,
  input  logic [BASE_W-1:0]   cfg_data
);

  state_t state, state_next;

  logic [BASE_W-1:0]        wait_base;
  logic [MAX_FRAGMENTS-1:0] rx_map;
  logic [CNT_W-1:0]         total;
  logic [IDX_W-1:0]         final_index;
  logic [WORD_W-1:0]        elapsed;
  logic [WORD_W-1:0]        cur_wait;
  logic [MAYDAY_W-1:0]      maydays;
  logic [WORD_W-1:0]        product;
  logic [IDX_W-1:0]         frag_q;
  logic [IDX_W-1:0]         lfi_q;
  logic [IDX_W-1:0]         scan_idx;
  logic                     pend_valid;
  logic [IDX_W-1:0]         pend_idx;
  logic                     emit_pending;
  status_t                  emit_status;
  logic [IDX_W-1:0]         emit_missing;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [WORD_W-1:0] mul_res;
  logic [CNT_W-1:0]  total_inc;
  logic              slot_free;
  logic              push;
  out_item_t         push_item;
  out_item_t         out_item;
  logic              scan_missing;
  logic              scan_stall;
  logic              scan_end;
  logic              in_fire;

  frnt_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  frnt_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .free      (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .item      (out_item)
  );

  assign status         = out_item.status;
  assign missing_index  = out_item.missing_index;
  assign last           = out_item.last;
  assign received_count = out_item.received_count;
  assign mayday_count   = out_item.mayday_count;

  assign in_ready = (state == S_IDLE) && !emit_pending;
  assign in_fire  = in_valid && in_ready;

  assign mul_res   = WORD_W'(wait_base) * WORD_W'(maydays);
  assign total_inc = (total < CNT_W'(MAX_FRAGMENTS)) ? total + 1'b1 : total;

  assign scan_missing = !rx_map[scan_idx];
  // A new missing index pushes out the one held back; that needs a free slot.
  assign scan_stall   = scan_missing && pend_valid && !slot_free;
  assign scan_end     = (scan_idx == final_index);

  always_comb begin
    alu_req = '0;
    unique case (state)
      S_FRAG: begin
        alu_req.a = WORD_W'(final_index);
        alu_req.b = WORD_W'(frag_q);
      end
      S_TICK_INC: begin
        alu_req.a = elapsed;
        alu_req.b = WORD_W'(1);
      end
      S_TICK_CMP: begin
        alu_req.a = elapsed;
        alu_req.b = cur_wait;
      end
      S_TICK_ADD: begin
        alu_req.a = cur_wait;
        alu_req.b = product;
      end
      default: alu_req = '0;
    endcase
  end

  // Result pushes: the final item of any input, or a held-back missing index.
  always_comb begin
    push_item                = '0;
    push_item.received_count = total;
    push_item.mayday_count   = maydays;
    push                     = 1'b0;
    if (emit_pending) begin
      push                    = slot_free;
      push_item.status        = emit_status;
      push_item.missing_index = emit_missing;
      push_item.last          = 1'b1;
    end else if (state == S_LIST && scan_missing && pend_valid && slot_free) begin
      push                    = 1'b1;
      push_item.status        = ST_MISSING;
      push_item.missing_index = pend_idx;
      push_item.last          = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd_t'(command))
            CMD_START: state_next = S_START;
            CMD_FRAG:  state_next = S_FRAG;
            CMD_TICK:  state_next = S_TICK_INC;
            CMD_LIST:  state_next = S_LIST;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_START:    state_next = S_IDLE;
      S_FRAG:     state_next = S_IDLE;
      S_TICK_INC: state_next = S_TICK_CMP;
      S_TICK_CMP: state_next = alu_rsp.ge ? S_TICK_MUL : S_IDLE;
      S_TICK_MUL: state_next = S_TICK_ADD;
      S_TICK_ADD: state_next = S_IDLE;
      S_LIST:     state_next = (!scan_stall && scan_end) ? S_IDLE : S_LIST;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_base    <= WAIT_BASE_RESET;
      rx_map       <= '0;
      total        <= '0;
      final_index  <= '0;
      elapsed      <= '0;
      cur_wait     <= WORD_W'(WAIT_BASE_RESET);
      maydays      <= '0;
      pend_valid   <= 1'b0;
      emit_pending <= 1'b0;
    end else begin
      if (cfg_we) begin
        wait_base <= cfg_data;
      end
      if (push && emit_pending) begin
        emit_pending <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            pend_valid <= 1'b0;
          end
        end
        S_START: begin
          // A 6-bit index can never exceed the last map entry.
          final_index  <= lfi_q;
          rx_map       <= '0;
          total        <= '0;
          elapsed      <= '0;
          cur_wait     <= WORD_W'(wait_base);
          maydays      <= '0;
          emit_pending <= 1'b1;
        end
        S_FRAG: begin
          emit_pending <= 1'b1;
          if (alu_rsp.ge && !rx_map[frag_q]) begin
            rx_map[frag_q] <= 1'b1;
            total          <= total_inc;
            elapsed        <= '0;
            cur_wait       <= WORD_W'(wait_base);
            maydays        <= '0;
          end
        end
        S_TICK_INC: begin
          elapsed <= alu_rsp.sum_sat;
        end
        S_TICK_CMP: begin
          if (alu_rsp.ge) begin
            if (maydays != MAYDAY_MAX) begin
              maydays <= maydays + 1'b1;
            end
          end else begin
            emit_pending <= 1'b1;
          end
        end
        S_TICK_MUL: ;
        S_TICK_ADD: begin
          cur_wait     <= alu_rsp.sum_sat;
          emit_pending <= 1'b1;
        end
        S_LIST: begin
          if (!scan_stall) begin
            if (scan_missing) begin
              pend_valid <= 1'b1;
            end
            if (scan_end) begin
              emit_pending <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and scan registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      frag_q   <= frag_index;
      lfi_q    <= last_fragment_index;
      scan_idx <= '0;
    end
    unique case (state)
      S_START: begin
        emit_status  <= ST_STARTED;
        emit_missing <= '0;
      end
      S_FRAG: begin
        emit_missing <= '0;
        if (!alu_rsp.ge) begin
          emit_status <= ST_OUT_OF_RANGE;
        end else if (rx_map[frag_q]) begin
          emit_status <= ST_DUPLICATE;
        end else if (total_inc > CNT_W'(final_index)) begin
          emit_status <= ST_COMPLETE;
        end else begin
          emit_status <= ST_ACCEPTED;
        end
      end
      S_TICK_CMP: begin
        emit_status  <= ST_NO_MAYDAY;
        emit_missing <= '0;
      end
      S_TICK_MUL: begin
        product <= mul_res;
      end
      S_TICK_ADD: begin
        emit_status  <= ST_MAYDAY;
        emit_missing <= '0;
      end
      S_LIST: begin
        if (!scan_stall) begin
          if (scan_missing) begin
            pend_idx <= scan_idx;
          end
          if (scan_end) begin
            emit_status  <= (scan_missing || pend_valid) ? ST_MISSING : ST_NONE_MISSING;
            emit_missing <= scan_missing ? scan_idx : (pend_valid ? pend_idx : '0);
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/frnt_checker.sv @@
// Port-level checker for the tracker, bound to the top level.
module frnt_checker
  import frnt_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [3:0]          status,
  input logic [IDX_W-1:0]    missing_index,
  input logic                last,
  input logic [MAYDAY_W-1:0] mayday_count
);

  // A stalled result must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(missing_index)
      && $stable(last) && $stable(mayday_count))
    else $error("result changed while stalled");

  // Every item keeps the block busy in the cycle after it is accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  a_index_only_missing: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_MISSING |-> missing_index == '0)
    else $error("missing index set on a non-missing result");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_MISSING |-> last)
    else $error("single result without last");

  // Start and a newly accepted fragment restart the backoff.
  a_backoff_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_STARTED || status == ST_ACCEPTED || status == ST_COMPLETE)
      |-> mayday_count == '0)
    else $error("mayday count not cleared on restart");

endmodule

bind fragment_reassembly_nack_tracker_core frnt_checker u_frnt_checker (.*);

@@ bench/nack_tracker_monitor.sv @@
`timescale 1ns / 1ps
// Channel monitor that predicts and checks every result of the NACK tracker.
module nack_tracker_monitor
  import frnt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [1:0]          command,
  input  logic [IDX_W-1:0]    frag_index,
  input  logic [IDX_W-1:0]    last_fragment_index,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [3:0]          status,
  input  logic [IDX_W-1:0]    missing_index,
  input  logic                last,
  input  logic [CNT_W-1:0]    received_count,
  input  logic [MAYDAY_W-1:0] mayday_count,
  input  logic                cfg_we,
  input  logic [BASE_W-1:0]   cfg_data,
  output int                  errors,
  output int                  pending,
  output int                  checked,
  output int                  mayday_results
);

  // Tracker state as the block should hold it.
  logic [MAX_FRAGMENTS-1:0] got_map;
  logic [CNT_W-1:0]         got_total;
  logic [IDX_W-1:0]         final_idx;
  logic [WORD_W-1:0]        elapsed;
  logic [WORD_W-1:0]        cur_wait;
  logic [MAYDAY_W-1:0]      maydays;
  logic [BASE_W-1:0]        base;

  out_item_t due_results[$];
  int n_err;
  int n_checked;
  int n_mayday;

  task automatic rearm_backoff();
    elapsed  = '0;
    cur_wait = WORD_W'(base);
    maydays  = '0;
  endtask

  task automatic queue_result(status_t st, logic [IDX_W-1:0] idx, logic fin);
    out_item_t r;
    r.status         = st;
    r.missing_index  = idx;
    r.last           = fin;
    r.received_count = got_total;
    r.mayday_count   = maydays;
    due_results.push_back(r);
  endtask

  task automatic track_item(cmd_t cmd, logic [IDX_W-1:0] fi, logic [IDX_W-1:0] lfi);
    logic [WORD_W:0] grown;
    int i;
    int top_gap;
    case (cmd)
      CMD_START: begin
        final_idx = lfi;
        got_map   = '0;
        got_total = '0;
        rearm_backoff();
        queue_result(ST_STARTED, '0, 1'b1);
      end
      CMD_FRAG: begin
        if (fi > final_idx) begin
          queue_result(ST_OUT_OF_RANGE, '0, 1'b1);
        end else if (got_map[fi]) begin
          queue_result(ST_DUPLICATE, '0, 1'b1);
        end else begin
          got_map[fi] = 1'b1;
          rearm_backoff();
          if (got_total < MAX_FRAGMENTS) got_total++;
          queue_result((got_total > final_idx) ? ST_COMPLETE : ST_ACCEPTED, '0, 1'b1);
        end
      end
      CMD_TICK: begin
        if (elapsed != '1) elapsed++;
        if (elapsed >= cur_wait) begin
          if (maydays != MAYDAY_MAX) maydays++;
          grown = {1'b0, cur_wait} + {1'b0, WORD_W'(base) * WORD_W'(maydays)};
          cur_wait = grown[WORD_W] ? '1 : grown[WORD_W-1:0];
          queue_result(ST_MAYDAY, '0, 1'b1);
        end else begin
          queue_result(ST_NO_MAYDAY, '0, 1'b1);
        end
      end
      default: begin
        // The highest missing index carries the last flag.
        top_gap = -1;
        for (i = 0; i <= final_idx; i++) begin
          if (!got_map[i]) top_gap = i;
        end
        if (top_gap < 0) begin
          queue_result(ST_NONE_MISSING, '0, 1'b1);
        end else begin
          for (i = 0; i <= final_idx; i++) begin
            if (!got_map[i]) queue_result(ST_MISSING, IDX_W'(i), i == top_gap);
          end
        end
      end
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      n_err++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    out_item_t want;
    if (due_results.size() == 0) begin
      n_err++;
      $display("%0t ns: result with status %0d arrived with nothing expected", $time, status);
    end else begin
      want = due_results.pop_front();
      check_field("status", want.status, status);
      check_field("missing_index", want.missing_index, missing_index);
      check_field("last", want.last, last);
      check_field("received_count", want.received_count, received_count);
      check_field("mayday_count", want.mayday_count, mayday_count);
      n_checked++;
      if (want.status == ST_MAYDAY) n_mayday++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      base      = WAIT_BASE_RESET;
      got_map   = '0;
      got_total = '0;
      final_idx = '0;
      elapsed   = '0;
      cur_wait  = WORD_W'(WAIT_BASE_RESET);
      maydays   = '0;
      n_err     = 0;
      n_checked = 0;
      n_mayday  = 0;
      due_results.delete();
    end else begin
      if (cfg_we) base = cfg_data;
      if (in_valid && in_ready) track_item(cmd_t'(command), frag_index, last_fragment_index);
      if (out_valid && out_ready) check_result();
    end
    errors         <= n_err;
    pending        <= due_results.size();
    checked        <= n_checked;
    mayday_results <= n_mayday;
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Testbench top: stimulus, handshake pacing, watchdog and verdict for the NACK tracker.
module tb;
  import frnt_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          command;
  logic [IDX_W-1:0]    frag_index;
  logic [IDX_W-1:0]    last_fragment_index;
  logic                out_valid;
  logic                out_ready;
  logic [3:0]          status;
  logic [IDX_W-1:0]    missing_index;
  logic                last;
  logic [CNT_W-1:0]    received_count;
  logic [MAYDAY_W-1:0] mayday_count;
  logic                cfg_we;
  logic [BASE_W-1:0]   cfg_data;

  int fail_count;
  int pending;
  int checked;
  int mayday_results;
  int items_sent;
  bit send_calm;
  bit rush;
  bit squeeze_req;

  always #4 clk = ~clk;

  fragment_reassembly_nack_tracker_core uut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .command             (command),
    .frag_index          (frag_index),
    .last_fragment_index (last_fragment_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .status              (status),
    .missing_index       (missing_index),
    .last                (last),
    .received_count      (received_count),
    .mayday_count        (mayday_count),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data)
  );

  nack_tracker_monitor tracker_check (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .command             (command),
    .frag_index          (frag_index),
    .last_fragment_index (last_fragment_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .status              (status),
    .missing_index       (missing_index),
    .last                (last),
    .received_count      (received_count),
    .mayday_count        (mayday_count),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data),
    .errors              (fail_count),
    .pending             (pending),
    .checked             (checked),
    .mayday_results      (mayday_results)
  );

  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom_range(0, MAX_FRAGMENTS - 1));
  endfunction

  // Valid stays high into the next item when there is no gap, so it is
  // never lowered and raised within one time step.
  task automatic send_item(cmd_t cmd, logic [IDX_W-1:0] fi, logic [IDX_W-1:0] lfi);
    int gap;
    gap = (send_calm || rush) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    command             <= cmd;
    frag_index          <= fi;
    last_fragment_index <= lfi;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // The register is written only once every result has been taken.
  task automatic set_wait_base(logic [BASE_W-1:0] value);
    drain();
    repeat (8) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Receiver pacing, including one long hold-off while the sender keeps going.
  initial begin
    int stall;
    int taken;
    bit calm;
    bit squeezed;
    out_ready = 1'b0;
    taken = 0;
    calm = 1'b0;
    squeezed = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken % 37 == 0) calm = ($urandom_range(0, 3) == 0);
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = (calm || rush) ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("tb: no handshake for %0d cycles", idle);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int p;
    int top_idx;
    int left;
    int roll;
    int idx;
    int phase_end;
    logic [MAX_FRAGMENTS-1:0] have;
    logic [BASE_W-1:0] bases [6];

    rst                 = 1'b1;
    in_valid            = 1'b0;
    command             = CMD_START;
    frag_index          = '0;
    last_fragment_index = '0;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    items_sent          = 0;
    send_calm           = 1'b0;
    rush                = 1'b0;
    squeeze_req         = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Out of reset the block acts as if a one-fragment message had started.
    send_item(CMD_LIST, any_index(), any_index());
    send_item(CMD_FRAG, 6'd0, any_index());
    send_item(CMD_FRAG, 6'd0, any_index());
    send_item(CMD_FRAG, 6'd63, any_index());
    send_item(CMD_LIST, any_index(), any_index());
    send_item(CMD_TICK, any_index(), any_index());
    send_item(CMD_START, any_index(), 6'd63);
    send_item(CMD_FRAG, 6'd63, 6'd0);
    send_item(CMD_FRAG, 6'd0, 6'd63);
    send_item(CMD_FRAG, 6'd63, any_index());
    send_item(CMD_LIST, any_index(), any_index());
    send_item(CMD_TICK, any_index(), any_index());

    // Small base: the wait grows by base times the mayday count.
    set_wait_base(16'd1);
    send_item(CMD_START, 6'd63, 6'd2);
    repeat (4) send_item(CMD_TICK, any_index(), any_index());
    send_item(CMD_FRAG, 6'd1, any_index());
    send_item(CMD_FRAG, 6'd0, any_index());
    send_item(CMD_FRAG, 6'd2, any_index());
    repeat (2) send_item(CMD_TICK, any_index(), any_index());
    send_item(CMD_LIST, any_index(), any_index());
    send_item(CMD_FRAG, 6'd2, any_index());

    // Zero base makes every tick a mayday.
    set_wait_base(16'd0);
    rush = 1'b1;
    send_item(CMD_START, any_index(), 6'd5);
    repeat (6) send_item(CMD_TICK, any_index(), any_index());
    send_item(CMD_LIST, any_index(), any_index());
    send_item(CMD_FRAG, 6'd3, any_index());
    rush = 1'b0;

    bases[0] = 16'hFFFF;
    bases[1] = 16'd1;
    bases[2] = BASE_W'($urandom_range(2, 6));
    bases[3] = 16'd1;
    bases[4] = BASE_W'($urandom_range(1, 65535));
    bases[5] = 16'd2;
    for (p = 0; p < 6; p++) begin
      set_wait_base(bases[p]);
      send_calm = ($urandom_range(0, 2) == 0);
      if (p == 3) begin
        send_calm = 1'b1;
        squeeze_req = 1'b1;
      end
      phase_end = items_sent + 40;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 10) begin
          send_item(cmd_t'($urandom_range(0, 3)), any_index(), any_index());
        end else begin
          top_idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
          send_item(CMD_START, any_index(), IDX_W'(top_idx));
          have = '0;
          left = top_idx + 1;
          while (left > 0 && items_sent < phase_end + 60) begin
            roll = $urandom_range(0, 99);
            if (roll < 72) begin
              idx = $urandom_range(0, top_idx);
              if (roll < 55) begin
                while (have[idx]) idx = (idx == top_idx) ? 0 : idx + 1;
              end else if (roll >= 65) begin
                idx = $urandom_range(0, 63);
              end
              send_item(CMD_FRAG, IDX_W'(idx), any_index());
              if (idx <= top_idx && !have[idx]) begin
                have[idx] = 1'b1;
                left--;
              end
            end else if (roll < 92) begin
              repeat ($urandom_range(1, 6)) send_item(CMD_TICK, any_index(), any_index());
            end else begin
              send_item(CMD_LIST, any_index(), any_index());
            end
          end
          // A finished message: duplicates, ticks and an empty missing list.
          repeat ($urandom_range(0, 2)) begin
            send_item(cmd_t'($urandom_range(1, 3)), IDX_W'($urandom_range(0, top_idx)),
                      any_index());
          end
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("tb: %0d items sent, %0d results checked, %0d of them maydays",
             items_sent, checked, mayday_results);
    $display("tb: wait bases 1000, 0, 1, 2, 65535 and random; one long receiver hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
